// File: design/image_stream_carver_assert.svh
// assertion macros shared by the carver modules
`ifndef IMAGE_STREAM_CARVER_ASSERT_SVH
`define IMAGE_STREAM_CARVER_ASSERT_SVH
`ifndef SYNTHESIS
`define ISC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
`define ISC_ASSERT_IMP(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error(msg);
`else
`define ISC_ASSERT(lbl, prop, msg)
`define ISC_ASSERT_IMP(lbl, pre, post, msg)
`endif
`endif

// File: design/isc_pkg.sv
// shared types, constants and helpers of the image stream carver
package isc_pkg;

  localparam int CountBits = 32;
  localparam int QDepth    = 4;
  localparam int QPtrW     = $clog2(QDepth);
  localparam int QCntW     = $clog2(QDepth + 1);

  typedef enum logic [1:0] {
    FmtJpeg = 2'd0,
    FmtPng  = 2'd1,
    FmtGif  = 2'd2
  } fmt_e;

  typedef enum logic [3:0] {
    GsBetween  = 4'd0,
    GsHeader   = 4'd1,
    GsGct      = 4'd2,
    GsExtLabel = 4'd3,
    GsDesc     = 4'd4,
    GsLct      = 4'd5,
    GsLzw      = 4'd6,
    GsSubSize  = 4'd7,
    GsSubData  = 4'd8
  } gif_sec_e;

  // one queued job: a whole signature or a single passed word
  typedef struct packed {
    logic       is_sig;
    fmt_e       fmt;
    logic [7:0] data;
    logic       last;
  } entry_t;

  function automatic logic [7:0] sig_byte(fmt_e fmt, logic [1:0] idx);
    logic [7:0] r;
    r = 8'h00;
    unique case (fmt)
      FmtJpeg: r = idx[0] ? 8'hD8 : 8'hFF;
      FmtPng: begin
        case (idx)
          2'd0:    r = 8'h89;
          2'd1:    r = 8'h50;
          2'd2:    r = 8'h4E;
          default: r = 8'h47;
        endcase
      end
      default: begin
        case (idx)
          2'd0:    r = 8'h47;
          2'd1:    r = 8'h49;
          2'd2:    r = 8'h46;
          default: r = 8'h38;
        endcase
      end
    endcase
    return r;
  endfunction

  function automatic logic [1:0] sig_last_idx(fmt_e fmt);
    return (fmt == FmtJpeg) ? 2'd1 : 2'd3;
  endfunction

  function automatic logic [7:0] png_sig_at(logic [1:0] p);
    return sig_byte(FmtPng, p);
  endfunction

  function automatic logic [7:0] gif_sig_at(logic [1:0] p);
    return sig_byte(FmtGif, p);
  endfunction

  function automatic logic [7:0] png_tail_at(logic [2:0] p);
    logic [7:0] r;
    case (p)
      3'd0:    r = 8'h49;
      3'd1:    r = 8'h45;
      3'd2:    r = 8'h4E;
      3'd3:    r = 8'h44;
      3'd4:    r = 8'hAE;
      3'd5:    r = 8'h42;
      3'd6:    r = 8'h60;
      default: r = 8'h82;
    endcase
    return r;
  endfunction

  // colour table length, zero when the table flag is clear
  function automatic logic [9:0] table_size(logic [7:0] packed_b);
    return packed_b[7] ? (10'd3 << ({1'b0, packed_b[2:0]} + 4'd1)) : 10'd0;
  endfunction

endpackage

// File: design/isc_front.sv
// front end: signature scanners, format end walkers and byte counter
`include "image_stream_carver_assert.svh"
module isc_front import isc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [31:0] cfg_data_i,
  input  logic        accept_i,
  input  logic [7:0]  data_byte_i,
  input  logic        restart_i,
  output logic        ent_valid_o,
  output entry_t      ent_o
);
  localparam int CmpW = (CountBits > 32) ? CountBits : 32;

  logic [31:0]          cl_q;
  logic                 in_image_q, in_image_d, finished_q, finished_d;
  fmt_e                 fmt_q, fmt_d;
  logic [CountBits-1:0] bc_q, bc_d;
  logic [1:0]           png_sig_q, png_sig_d;
  logic [2:0]           png_tail_q, png_tail_d;
  logic [16:0]          jpeg_pos_q, jpeg_pos_d;
  logic [15:0]          jpeg_len_q, jpeg_len_d;
  logic                 jpeg_scan_q, jpeg_scan_d;
  logic [9:0]           gif_pos_q, gif_pos_d, gif_tgt_q, gif_tgt_d;
  gif_sec_e             gif_sec_q, gif_sec_d;

  always_comb begin
    logic [7:0]  b;
    logic        found, wend;
    fmt_e        ffmt;
    logic [15:0] len;
    b = data_byte_i;
    found = 1'b0;
    wend = 1'b0;
    ffmt = FmtJpeg;
    len = 16'd0;
    in_image_d  = in_image_q;
    finished_d  = finished_q;
    fmt_d       = fmt_q;
    bc_d        = bc_q;
    png_sig_d   = png_sig_q;
    png_tail_d  = png_tail_q;
    jpeg_pos_d  = jpeg_pos_q;
    jpeg_len_d  = jpeg_len_q;
    jpeg_scan_d = jpeg_scan_q;
    gif_pos_d   = gif_pos_q;
    gif_tgt_d   = gif_tgt_q;
    gif_sec_d   = gif_sec_q;
    ent_valid_o = 1'b0;
    ent_o       = '0;
    if (restart_i) begin
      in_image_d = 1'b0; finished_d = 1'b0; fmt_d = FmtJpeg; bc_d = '0;
      png_sig_d = '0; png_tail_d = '0; jpeg_pos_d = '0; jpeg_len_d = '0;
      jpeg_scan_d = 1'b0; gif_pos_d = '0; gif_tgt_d = '0; gif_sec_d = GsBetween;
    end
    if (finished_d) begin
      // image already closed, wait for restart
    end else if (!in_image_d) begin
      if (b == png_sig_at(png_sig_d)) begin
        if (png_sig_d == 2'd3) begin found = 1'b1; ffmt = FmtPng; end
        else png_sig_d = png_sig_d + 2'd1;
      end else begin
        png_sig_d = (b == 8'h89) ? 2'd1 : 2'd0;
      end
      if (jpeg_pos_d == 17'd1 && b == 8'hD8) begin
        found = 1'b1; ffmt = FmtJpeg;
      end else begin
        jpeg_pos_d = (b == 8'hFF) ? 17'd1 : 17'd0;
      end
      if (b == gif_sig_at(gif_pos_d[1:0])) begin
        if (gif_pos_d[1:0] == 2'd3) begin found = 1'b1; ffmt = FmtGif; end
        else gif_pos_d = {8'd0, gif_pos_d[1:0] + 2'd1};
      end else begin
        gif_pos_d = (b == 8'h47) ? 10'd1 : 10'd0;
      end
      if (found) begin
        in_image_d = 1'b1; fmt_d = ffmt;
        png_tail_d = '0; jpeg_pos_d = '0; jpeg_len_d = '0; jpeg_scan_d = 1'b0;
        gif_pos_d = 10'd4; gif_tgt_d = '0; gif_sec_d = GsHeader;
        bc_d = CountBits'({1'b0, sig_last_idx(ffmt)}) + CountBits'(1);
        finished_d = (cl_q != 32'd0) && (CmpW'(bc_d) >= CmpW'(cl_q));
        ent_valid_o = 1'b1;
        ent_o.is_sig = 1'b1; ent_o.fmt = ffmt; ent_o.data = 8'h00;
        ent_o.last = finished_d;
      end
    end else begin
      if (bc_d != '1) bc_d = bc_d + CountBits'(1);
      if (cl_q != 32'd0) begin
        wend = CmpW'(bc_d) >= CmpW'(cl_q);
      end else if (fmt_d == FmtPng) begin
        if (b == png_tail_at(png_tail_d)) begin
          if (png_tail_d == 3'd7) begin wend = 1'b1; png_tail_d = 3'd0; end
          else png_tail_d = png_tail_d + 3'd1;
        end else begin
          png_tail_d = (b == 8'h49) ? 3'd1 : 3'd0;
        end
      end else if (fmt_d == FmtJpeg) begin
        if (jpeg_scan_d) begin
          if (jpeg_pos_d == 17'd1 && b == 8'hD9) wend = 1'b1;
          else jpeg_pos_d = (b == 8'hFF) ? 17'd1 : 17'd0;
        end else if (jpeg_pos_d == 17'd0) begin
          if (b == 8'hFF) jpeg_pos_d = 17'd1;
        end else if (jpeg_pos_d == 17'd1) begin
          if (b == 8'hFF) begin
            // fill byte
          end else if (b == 8'hD9) begin
            wend = 1'b1;
          end else if (b == 8'hDA) begin
            jpeg_scan_d = 1'b1; jpeg_pos_d = 17'd0;
          end else if (b == 8'hD8 || b == 8'h01 || b[7:3] == 5'b11010) begin
            jpeg_pos_d = 17'd0;
          end else begin
            jpeg_pos_d = 17'd2;
          end
        end else if (jpeg_pos_d == 17'd2) begin
          jpeg_len_d = {b, 8'h00}; jpeg_pos_d = 17'd3;
        end else if (jpeg_pos_d == 17'd3) begin
          len = jpeg_len_d | {8'h00, b};
          jpeg_len_d = len;
          jpeg_pos_d = (len <= 16'd2) ? 17'd0 : 17'd4;
        end else begin
          if (jpeg_pos_d >= {1'b0, jpeg_len_d} + 17'd1) jpeg_pos_d = 17'd0;
          else jpeg_pos_d = jpeg_pos_d + 17'd1;
        end
      end else begin
        unique case (gif_sec_d)
          GsHeader: begin
            if (gif_pos_d == 10'd10) gif_tgt_d = table_size(b);
            if (gif_pos_d >= 10'd12) begin
              gif_pos_d = '0;
              gif_sec_d = (gif_tgt_d != '0) ? GsGct : GsBetween;
            end else gif_pos_d = gif_pos_d + 10'd1;
          end
          GsGct, GsLct: begin
            gif_pos_d = gif_pos_d + 10'd1;
            if (gif_pos_d >= gif_tgt_d) begin
              gif_pos_d = '0;
              gif_sec_d = (gif_sec_d == GsGct) ? GsBetween : GsLzw;
            end
          end
          GsDesc: begin
            if (gif_pos_d == 10'd8) begin
              gif_tgt_d = table_size(b); gif_pos_d = '0;
              gif_sec_d = (gif_tgt_d != '0) ? GsLct : GsLzw;
            end else gif_pos_d = gif_pos_d + 10'd1;
          end
          GsExtLabel, GsLzw: gif_sec_d = GsSubSize;
          GsSubSize: begin
            if (b == 8'h00) gif_sec_d = GsBetween;
            else begin gif_tgt_d = {2'b00, b}; gif_pos_d = '0; gif_sec_d = GsSubData; end
          end
          GsSubData: begin
            gif_pos_d = gif_pos_d + 10'd1;
            if (gif_pos_d >= gif_tgt_d) begin gif_pos_d = '0; gif_sec_d = GsSubSize; end
          end
          default: begin
            gif_sec_d = GsBetween;
            if (b == 8'h2C) begin gif_pos_d = '0; gif_sec_d = GsDesc; end
            else if (b == 8'h21) gif_sec_d = GsExtLabel;
            else if (b == 8'h3B) wend = 1'b1;
          end
        endcase
      end
      if (wend) finished_d = 1'b1;
      ent_valid_o = 1'b1;
      ent_o.is_sig = 1'b0; ent_o.fmt = fmt_d; ent_o.data = b; ent_o.last = wend;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cl_q <= '0; in_image_q <= 1'b0; finished_q <= 1'b0; fmt_q <= FmtJpeg;
      bc_q <= '0; png_sig_q <= '0; png_tail_q <= '0; jpeg_pos_q <= '0;
      jpeg_len_q <= '0; jpeg_scan_q <= 1'b0; gif_pos_q <= '0; gif_tgt_q <= '0;
      gif_sec_q <= GsBetween;
    end else begin
      if (cfg_we_i) cl_q <= cfg_data_i;
      if (accept_i) begin
        in_image_q <= in_image_d; finished_q <= finished_d; fmt_q <= fmt_d;
        bc_q <= bc_d; png_sig_q <= png_sig_d; png_tail_q <= png_tail_d;
        jpeg_pos_q <= jpeg_pos_d; jpeg_len_q <= jpeg_len_d; jpeg_scan_q <= jpeg_scan_d;
        gif_pos_q <= gif_pos_d; gif_tgt_q <= gif_tgt_d; gif_sec_q <= gif_sec_d;
      end
    end
  end

  `ISC_ASSERT_IMP(a_fin_in_image, finished_q, in_image_q, "finished without image")
endmodule

// File: design/isc_queue.sv
// short job queue between front and back end
`include "image_stream_carver_assert.svh"
module isc_queue import isc_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   wr_i,
  input  entry_t wdata_i,
  input  logic   rd_i,
  output entry_t rdata_o,
  output logic   full_o,
  output logic   empty_o
);
  entry_t           mem_q [QDepth];
  logic [QPtrW-1:0] wp_q, rp_q;
  logic [QCntW-1:0] cnt_q;

  assign full_o  = (cnt_q == QCntW'(QDepth));
  assign empty_o = (cnt_q == '0);
  assign rdata_o = mem_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (wr_i) mem_q[wp_q] <= wdata_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= '0; rp_q <= '0; cnt_q <= '0;
    end else begin
      if (wr_i) wp_q <= wp_q + QPtrW'(1);
      if (rd_i) rp_q <= rp_q + QPtrW'(1);
      cnt_q <= cnt_q + QCntW'(wr_i) - QCntW'(rd_i);
    end
  end

  `ISC_ASSERT(a_cnt_bound, cnt_q <= QCntW'(QDepth), "queue count beyond depth")
  `ISC_ASSERT_IMP(a_ptr_gap, cnt_q == '0 || cnt_q == QCntW'(QDepth),
                  wp_q == rp_q, "pointers disagree with count")
endmodule

// File: design/isc_back.sv
// back end: expands signatures and drives the result register
`include "image_stream_carver_assert.svh"
module isc_back import isc_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       q_empty_i,
  input  entry_t     q_head_i,
  output logic       q_rd_o,
  input  logic       pop,
  output logic       empty,
  output logic [7:0] out_byte_o,
  output logic [1:0] format_o,
  output logic       last_o
);
  logic       vld_q, vld_d, last_q, last_d;
  logic [7:0] byte_q, byte_d;
  fmt_e       fmt_q, fmt_d;
  logic [1:0] idx_q, idx_d;
  logic       load;

  assign load = !vld_q || pop;

  always_comb begin
    vld_d = vld_q; byte_d = byte_q; fmt_d = fmt_q; last_d = last_q;
    idx_d = idx_q; q_rd_o = 1'b0;
    if (load) begin
      vld_d = !q_empty_i;
      if (!q_empty_i) begin
        fmt_d = q_head_i.fmt;
        if (q_head_i.is_sig) begin
          byte_d = sig_byte(q_head_i.fmt, idx_q);
          if (idx_q == sig_last_idx(q_head_i.fmt)) begin
            last_d = q_head_i.last; idx_d = 2'd0; q_rd_o = 1'b1;
          end else begin
            last_d = 1'b0; idx_d = idx_q + 2'd1;
          end
        end else begin
          byte_d = q_head_i.data; last_d = q_head_i.last; q_rd_o = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0; idx_q <= '0;
    end else begin
      vld_q <= vld_d; idx_q <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    byte_q <= byte_d; fmt_q <= fmt_d; last_q <= last_d;
  end

  assign empty      = !vld_q;
  assign out_byte_o = byte_q;
  assign format_o   = fmt_q;
  assign last_o     = last_q;

  `ISC_ASSERT_IMP(a_idx_sig, idx_q != 2'd0, !q_empty_i && q_head_i.is_sig,
                  "signature index without signature job")
endmodule

// File: design/image_stream_carver.sv
// image stream carver top level: front end, job queue and back end
// Finds one JPEG, PNG or GIF image in a byte stream and passes its words on. Every input word
// is taken back to back whenever full is low; the front end decides per word whether a result
// follows. The word that completes a signature yields its 2 or 4 signature words, which the
// back end sends one per cycle while pop takes them, so after a start the input may stall while
// the four-entry job queue drains. Results come from an output register, so a result may wait on
// pop while new input words are still taken. The end is the content_length count (signature
// included) when that register is non-zero, else the format's own end marker (PNG IEND chunk and
// CRC, JPEG EOI after the segment walk, GIF trailer after the block walk). After the last word
// nothing is sent until a word arrives with restart set. Write cfg only while idle.
`include "image_stream_carver_assert.svh"
module image_stream_carver import isc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration: expected image length, zero for marker based end
  input  logic        cfg_we_i,
  input  logic [31:0] cfg_data_i,
  // input side
  input  logic        push,
  output logic        full,
  input  logic [7:0]  data_byte_i,
  input  logic        restart_i,
  // result side
  output logic        empty,
  input  logic        pop,
  output logic [7:0]  out_byte_o,
  output logic [1:0]  format_o,
  output logic        last_o
);
  logic   accept, ent_valid, q_full, q_empty, q_rd;
  entry_t ent, q_head;

  // a word is taken only while the queue has room for its job
  assign full   = q_full;
  assign accept = push && !q_full;

  isc_front u_front (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_data_i,
    .accept_i(accept), .data_byte_i, .restart_i,
    .ent_valid_o(ent_valid), .ent_o(ent)
  );

  isc_queue u_queue (
    .clk_i, .rst_ni,
    .wr_i(accept && ent_valid), .wdata_i(ent),
    .rd_i(q_rd), .rdata_o(q_head), .full_o(q_full), .empty_o(q_empty)
  );

  isc_back u_back (
    .clk_i, .rst_ni,
    .q_empty_i(q_empty), .q_head_i(q_head), .q_rd_o(q_rd),
    .pop, .empty, .out_byte_o, .format_o, .last_o
  );

  `ISC_ASSERT_IMP(a_no_rd_empty, q_rd, !q_empty, "queue read while empty")
endmodule

// File: dv/image_stream_carver_tb.sv
// self-checking testbench of the image stream carver
`timescale 1ns / 1ps
module image_stream_carver_tb;
  import isc_pkg::*;

  localparam int    HalfPeriod = 6;
  localparam int    CycleLimit = 400000;
  localparam int    TailCycles = 40;
  localparam logic [63:0] CountMax = (64'd1 << CountBits) - 64'd1;

  typedef struct packed {
    logic [7:0] data;
    fmt_e       fmt;
    logic       last;
  } word_t;

  // one row of the directed table: input word and, where known, the expected words
  typedef struct {
    logic [7:0] data;
    logic       rst;
    int         n_chk;
    word_t      chk[4];
  } row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [31:0] cfg_data_i = '0;
  logic        push = 1'b0;
  logic        full;
  logic [7:0]  data_byte_i = '0;
  logic        restart_i = 1'b0;
  logic        empty;
  logic        pop = 1'b0;
  logic [7:0]  out_byte_o;
  logic [1:0]  format_o;
  logic        last_o;

  always #HalfPeriod clk_i = ~clk_i;

  image_stream_carver i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_data_i (cfg_data_i),
    .push       (push),
    .full       (full),
    .data_byte_i(data_byte_i),
    .restart_i  (restart_i),
    .empty      (empty),
    .pop        (pop),
    .out_byte_o (out_byte_o),
    .format_o   (format_o),
    .last_o     (last_o)
  );

  // predicted carver state
  logic [31:0] exp_len;
  logic        m_in_image, m_finished;
  fmt_e        m_fmt;
  logic [63:0] m_count;
  logic [1:0]  m_png_sig;
  logic [2:0]  m_png_tail;
  logic [16:0] m_jpos;
  logic [15:0] m_jlen;
  logic        m_jscan;
  logic [31:0] m_gpos, m_gtarget;
  gif_sec_e    m_gsec;

  word_t expected_words[$];
  int    n_errors = 0;
  int    n_cycles = 0;
  bit    no_idle = 1'b0;
  bit    long_hold = 1'b0;

  task automatic report_mismatch(input string what);
    $display("mismatch at %0t: %s", $realtime, what);
    n_errors++;
  endtask

  function automatic void clear_carver();
    m_in_image = 0; m_finished = 0; m_fmt = FmtJpeg; m_count = 0;
    m_png_sig = 0; m_png_tail = 0; m_jpos = 0; m_jlen = 0; m_jscan = 0;
    m_gpos = 0; m_gtarget = 0; m_gsec = GsBetween;
  endfunction

  function automatic logic [31:0] colour_table(logic [7:0] b);
    return b[7] ? (32'd3 << (b[2:0] + 1)) : 32'd0;
  endfunction

  function automatic logic [7:0] png_tail_byte(logic [2:0] p);
    logic [63:0] t;
    t = 64'h49454E44AE426082;
    return t[63 - 8 * p -: 8];
  endfunction

  function automatic logic [7:0] sig_of(fmt_e f, int k);
    case (f)
      FmtJpeg: return k ? 8'hD8 : 8'hFF;
      FmtPng:  return 8'((32'h89504E47 >> (8 * (3 - k))) & 32'hFF);
      default: return 8'((32'h47494638 >> (8 * (3 - k))) & 32'hFF);
    endcase
  endfunction

  function automatic bit png_end(logic [7:0] b);
    if (b == png_tail_byte(m_png_tail)) begin
      if (m_png_tail == 3'd7) begin
        m_png_tail = 0;
        return 1;
      end
      m_png_tail++;
    end else begin
      m_png_tail = (b == 8'h49) ? 3'd1 : 3'd0;
    end
    return 0;
  endfunction

  function automatic bit jpeg_end(logic [7:0] b);
    if (m_jscan) begin
      if (m_jpos == 1 && b == 8'hD9) return 1;
      m_jpos = (b == 8'hFF) ? 17'd1 : 17'd0;
      return 0;
    end
    if (m_jpos == 0) begin
      if (b == 8'hFF) m_jpos = 1;
    end else if (m_jpos == 1) begin
      if (b == 8'hFF) return 0;
      if (b == 8'hD9) return 1;
      if (b == 8'hDA) begin
        m_jscan = 1; m_jpos = 0;
      end else if (b == 8'hD8 || b == 8'h01 || (b >= 8'hD0 && b <= 8'hD7)) begin
        m_jpos = 0;
      end else begin
        m_jpos = 2;
      end
    end else if (m_jpos == 2) begin
      m_jlen = {b, 8'h00}; m_jpos = 3;
    end else if (m_jpos == 3) begin
      m_jlen = m_jlen | {8'h00, b};
      m_jpos = (m_jlen <= 2) ? 17'd0 : 17'd4;
    end else begin
      if ({15'd0, m_jpos} >= {16'd0, m_jlen} + 32'd1) m_jpos = 0;
      else m_jpos++;
    end
    return 0;
  endfunction

  function automatic bit gif_end(logic [7:0] b);
    case (m_gsec)
      GsHeader: begin
        if (m_gpos == 10) m_gtarget = colour_table(b);
        if (m_gpos >= 12) begin
          m_gpos = 0;
          m_gsec = (m_gtarget != 0) ? GsGct : GsBetween;
        end else begin
          m_gpos++;
        end
      end
      GsGct, GsLct: begin
        m_gpos++;
        if (m_gpos >= m_gtarget) begin
          m_gpos = 0;
          m_gsec = (m_gsec == GsGct) ? GsBetween : GsLzw;
        end
      end
      GsDesc: begin
        if (m_gpos == 8) begin
          m_gtarget = colour_table(b); m_gpos = 0;
          m_gsec = (m_gtarget != 0) ? GsLct : GsLzw;
        end else begin
          m_gpos++;
        end
      end
      GsExtLabel, GsLzw: m_gsec = GsSubSize;
      GsSubSize: begin
        if (b == 0) begin
          m_gsec = GsBetween;
        end else begin
          m_gtarget = {24'd0, b}; m_gpos = 0; m_gsec = GsSubData;
        end
      end
      GsSubData: begin
        m_gpos++;
        if (m_gpos >= m_gtarget) begin
          m_gpos = 0; m_gsec = GsSubSize;
        end
      end
      default: begin
        m_gsec = GsBetween;
        if (b == 8'h2C) begin
          m_gpos = 0; m_gsec = GsDesc;
        end else if (b == 8'h21) begin
          m_gsec = GsExtLabel;
        end else if (b == 8'h3B) begin
          return 1;
        end
      end
    endcase
    return 0;
  endfunction

  // works out the words one accepted input word yields and queues them
  function automatic int carve_word(logic [7:0] b, logic rst);
    int   fmt_hit, n;
    bit   fin;
    logic [1:0] p, g;
    if (rst) clear_carver();
    if (m_finished) return 0;
    if (!m_in_image) begin
      fmt_hit = -1;
      p = m_png_sig; g = m_gpos[1:0];
      if (b == sig_of(FmtPng, p)) begin
        if (p == 3) fmt_hit = FmtPng; else m_png_sig = p + 2'd1;
      end else begin
        m_png_sig = (b == 8'h89) ? 2'd1 : 2'd0;
      end
      if (m_jpos == 1 && b == 8'hD8) fmt_hit = FmtJpeg;
      else m_jpos = (b == 8'hFF) ? 17'd1 : 17'd0;
      if (b == sig_of(FmtGif, g)) begin
        if (g == 3) fmt_hit = FmtGif; else m_gpos = {30'd0, g + 2'd1};
      end else begin
        m_gpos = (b == 8'h47) ? 32'd1 : 32'd0;
      end
      if (fmt_hit < 0) return 0;
      m_in_image = 1;
      m_fmt = fmt_e'(fmt_hit);
      m_png_tail = 0; m_jpos = 0; m_jlen = 0; m_jscan = 0;
      m_gpos = 4; m_gtarget = 0; m_gsec = GsHeader;
      n = (m_fmt == FmtJpeg) ? 2 : 4;
      m_count = 64'(n);
      if (exp_len != 0 && m_count >= {32'd0, exp_len}) m_finished = 1;
      for (int k = 0; k < n; k++)
        expected_words.push_back('{sig_of(m_fmt, k), m_fmt, (k == n - 1) && m_finished});
      return n;
    end
    if (m_count < CountMax) m_count++;
    if (exp_len != 0) fin = m_count >= {32'd0, exp_len};
    else if (m_fmt == FmtPng) fin = png_end(b);
    else if (m_fmt == FmtJpeg) fin = jpeg_end(b);
    else fin = gif_end(b);
    if (fin) m_finished = 1;
    expected_words.push_back('{b, m_fmt, fin});
    return 1;
  endfunction

  // cycle limit watchdog
  always @(posedge clk_i) begin
    n_cycles++;
    if (n_cycles > CycleLimit) begin
      $display("status: fail");
      $finish;
    end
  end

  // result side: check at the rising edge, move pop at the falling edge
  always @(posedge clk_i) begin
    word_t w;
    if (rst_ni && pop && !empty) begin
      if (expected_words.size() == 0) begin
        report_mismatch($sformatf("unexpected word %02h", out_byte_o));
      end else begin
        w = expected_words.pop_front();
        if (out_byte_o !== w.data)
          report_mismatch($sformatf("out_byte %02h, want %02h", out_byte_o, w.data));
        if (format_o !== w.fmt)
          report_mismatch($sformatf("format %0d, want %0d", format_o, w.fmt));
        if (last_o !== w.last)
          report_mismatch($sformatf("last %0b, want %0b", last_o, w.last));
      end
    end
  end

  initial begin
    int gap;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (long_hold) begin
        // long hold-off so the queue fills and full stalls the sender
        pop <= 1'b0;
        for (int i = 0; i < 60; i++) @(negedge clk_i);
        long_hold = 0;
      end else if (!no_idle && $urandom_range(0, 7) == 0) begin
        gap = $urandom_range(1, 19);
        pop <= 1'b0;
        for (int i = 1; i < gap; i++) @(negedge clk_i);
      end else begin
        pop <= 1'b1;
      end
    end
  end

  // hands one word to the block, waiting for full low, keeping push high
  task automatic send_word(input logic [7:0] b, input logic rst);
    data_byte_i <= b;
    restart_i   <= rst;
    push        <= 1'b1;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    void'(carve_word(b, rst));
    @(negedge clk_i);
  endtask

  task automatic idle_sender();
    int gap;
    if (!no_idle && $urandom_range(0, 9) == 0) begin
      push <= 1'b0;
      gap = $urandom_range(1, 19);
      repeat (gap) @(negedge clk_i);
    end
  endtask

  task automatic drain();
    push <= 1'b0;
    while (expected_words.size() != 0) @(negedge clk_i);
    repeat (TailCycles) @(negedge clk_i);
  endtask

  task automatic write_length(input logic [31:0] v);
    cfg_we_i   <= 1'b1;
    cfg_data_i <= v;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    exp_len = v;
  endtask

  task automatic send_list(input logic [7:0] bytes[$], input logic first_rst);
    foreach (bytes[i]) begin
      send_word(bytes[i], first_rst && i == 0);
      idle_sender();
    end
  endtask

  // random stream shaped like one image of the given kind, with noise
  task automatic random_image(input int kind);
    logic [7:0] s[$];
    logic [7:0] pk;
    int n;
    repeat ($urandom_range(0, 3)) s.push_back(8'($urandom));
    case (kind)
      0: begin
        s.push_back(8'hFF); s.push_back(8'hD8);
        repeat ($urandom_range(0, 3)) begin
          s.push_back(8'hFF);
          if ($urandom_range(0, 3) == 0) s.push_back(8'hFF);
          if ($urandom_range(0, 3) == 0) begin
            s.push_back(8'($urandom_range(8'hD0, 8'hD7)));
          end else begin
            n = $urandom_range(0, 6);
            s.push_back($urandom_range(8'hC0, 8'hFE) == 8'hD9 ? 8'hE0 : 8'hE1);
            s.push_back(8'h00); s.push_back(8'(n));
            repeat (n > 2 ? n - 2 : 0) s.push_back(8'($urandom));
          end
        end
        s.push_back(8'hFF); s.push_back(8'hDA); s.push_back(8'hD9);
        repeat ($urandom_range(1, 10)) s.push_back(8'($urandom));
        s.push_back(8'hFF); s.push_back(8'hD9);
      end
      1: begin
        s.push_back(8'h89); s.push_back(8'h50); s.push_back(8'h4E); s.push_back(8'h47);
        repeat ($urandom_range(2, 12)) s.push_back(8'($urandom));
        s.push_back(8'h49); s.push_back(8'h49);
        s.push_back(8'h45); s.push_back(8'h4E); s.push_back(8'h44);
        s.push_back(8'hAE); s.push_back(8'h42); s.push_back(8'h60); s.push_back(8'h82);
      end
      default: begin
        s.push_back(8'h47); s.push_back(8'h49); s.push_back(8'h46); s.push_back(8'h38);
        repeat (6) s.push_back(8'($urandom));
        pk = {$urandom_range(0, 1) ? 1'b1 : 1'b0, 4'($urandom), 3'($urandom_range(0, 1))};
        s.push_back(pk); s.push_back(8'($urandom)); s.push_back(8'($urandom));
        repeat (colour_table(pk)) s.push_back(8'($urandom));
        if ($urandom_range(0, 1)) begin
          s.push_back(8'h21); s.push_back(8'($urandom)); s.push_back(8'h02);
          s.push_back(8'($urandom)); s.push_back(8'($urandom)); s.push_back(8'h00);
        end
        s.push_back(8'h00);
        s.push_back(8'h2C);
        repeat (8) s.push_back(8'($urandom));
        pk = {$urandom_range(0, 1) ? 1'b1 : 1'b0, 7'h00};
        s.push_back(pk);
        repeat (colour_table(pk)) s.push_back(8'($urandom));
        s.push_back(8'h02); s.push_back(8'h03);
        repeat (3) s.push_back(8'($urandom));
        s.push_back(8'h00); s.push_back(8'h3B);
      end
    endcase
    repeat ($urandom_range(0, 2)) s.push_back(8'($urandom));
    send_list(s, 1'b1);
  endtask

  initial begin
    row_t rows[$];
    row_t r;
    int   got;
    logic [31:0] lens[5];
    exp_len = 0;
    clear_carver();
    repeat (9) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // directed table: fixed expectations where obvious, else predictor only
    rows.push_back('{8'h00, 1'b1, 0, '{default: '0}});
    rows.push_back('{8'hFF, 1'b0, 0, '{default: '0}});
    rows.push_back('{8'hD8, 1'b0, 2, '{'{8'hFF, FmtJpeg, 1'b0}, '{8'hD8, FmtJpeg, 1'b0},
                                       '0, '0}});
    rows.push_back('{8'hFF, 1'b0, 1, '{'{8'hFF, FmtJpeg, 1'b0}, '0, '0, '0}});
    rows.push_back('{8'hD9, 1'b0, 1, '{'{8'hD9, FmtJpeg, 1'b1}, '0, '0, '0}});
    rows.push_back('{8'h55, 1'b0, 0, '{default: '0}});
    rows.push_back('{8'h89, 1'b1, 0, '{default: '0}});
    rows.push_back('{8'h89, 1'b0, 0, '{default: '0}});
    rows.push_back('{8'h50, 1'b0, 0, '{default: '0}});
    rows.push_back('{8'h4E, 1'b0, 0, '{default: '0}});
    rows.push_back('{8'h47, 1'b0, 4, '{'{8'h89, FmtPng, 1'b0}, '{8'h50, FmtPng, 1'b0},
                                       '{8'h4E, FmtPng, 1'b0}, '{8'h47, FmtPng, 1'b0}}});
    rows.push_back('{8'h49, 1'b0, -1, '{default: '0}});
    rows.push_back('{8'h47, 1'b1, 0, '{default: '0}});
    rows.push_back('{8'h49, 1'b0, 0, '{default: '0}});
    rows.push_back('{8'h46, 1'b0, 0, '{default: '0}});
    rows.push_back('{8'h38, 1'b0, 4, '{'{8'h47, FmtGif, 1'b0}, '{8'h49, FmtGif, 1'b0},
                                       '{8'h46, FmtGif, 1'b0}, '{8'h38, FmtGif, 1'b0}}});
    rows.push_back('{8'hFF, 1'b0, -1, '{default: '0}});
    rows.push_back('{8'h00, 1'b0, -1, '{default: '0}});
    foreach (rows[i]) begin
      r = rows[i];
      send_word(r.data, r.rst);
      if (r.n_chk >= 0) begin
        got = 0;
        for (int k = expected_words.size() - r.n_chk; k < expected_words.size(); k++) begin
          if (k >= 0 && expected_words[k] !== r.chk[got])
            report_mismatch($sformatf("directed row %0d word %0d", i, got));
          got++;
        end
      end
    end
    drain();

    // small count: the whole signature still comes, last on its final word
    write_length(32'd1);
    send_list('{8'hFF, 8'hD8, 8'h12}, 1'b1);
    drain();

    // random phases over several lengths, extremes included
    lens = '{32'd0, 32'd7, 32'd0, 32'hFFFF_FFFF, 32'd0};
    foreach (lens[p]) begin
      write_length(lens[p]);
      for (int k = 0; k < 2; k++) begin
        if (p == 0 && k == 0) long_hold = 1;
        if (p == 4 && k >= 1) no_idle = 1;
        random_image($urandom_range(0, 2));
        if ($urandom_range(0, 3) == 0) begin
          repeat ($urandom_range(1, 5)) send_word(8'($urandom), 1'($urandom_range(0, 1)));
        end
        if (p == 2 && k == 0) begin
          // sender pauses until everything is out
          push <= 1'b0;
          while (expected_words.size() != 0) @(negedge clk_i);
        end
      end
      drain();
    end

    drain();
    if (n_errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
